// File: design/srt_pkg.sv
`timescale 1ns / 1ps

package srt_pkg;

  typedef enum logic [2:0] {
    CMD_APPEND   = 3'd0,
    CMD_CLEAR    = 3'd1,
    CMD_FIND     = 3'd2,
    CMD_REBASE   = 3'd3,
    CMD_SET_FLAG = 3'd4
  } cmd_t;

  // request travelling down the cell chain, with the find result it collects
  typedef struct packed {
    cmd_t        cmd;
    logic        kind;
    logic        kind_ok;
    logic [31:0] spos;
    logic [31:0] epos;
    logic [31:0] pos;
    logic [31:0] delta;
    logic [31:0] prev_first_shift;
    logic [31:0] prev_last_shift;
    logic        done;
    logic        found;
    logic [31:0] hit_first;
    logic [31:0] hit_last;
    logic [31:0] hit_first_shift;
    logic [31:0] hit_last_shift;
  } token_t;

endpackage

// File: design/srt_cell.sv
`timescale 1ns / 1ps

module srt_cell import srt_pkg::*; #(
  parameter int KIND_COUNT = 2,
  parameter int IDX        = 0,
  parameter int CW         = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [CW-1:0] active_count,
  input  logic          in_valid,
  input  token_t        in_tok,
  output logic          out_valid,
  output token_t        out_tok
);

  localparam int KW = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1;

  logic [31:0] cell_first       [KIND_COUNT];
  logic [31:0] cell_last        [KIND_COUNT];
  logic [31:0] cell_first_shift [KIND_COUNT];
  logic [31:0] cell_last_shift  [KIND_COUNT];

  logic [KW-1:0] kidx;
  logic          live;
  logic          append_here;
  logic [31:0]   shifted_first;
  logic [31:0]   shifted_last;
  logic          move_first;
  logic          move_last;
  token_t        tok_next;

  assign kidx = KW'(in_tok.kind);
  assign live = in_valid && in_tok.kind_ok && (CW'(IDX) < active_count);
  assign append_here = in_valid && in_tok.kind_ok && (in_tok.cmd == CMD_APPEND) &&
                       (CW'(IDX) == active_count);

  assign shifted_first = cell_first[kidx] + cell_first_shift[kidx];
  assign shifted_last  = cell_last[kidx] + cell_last_shift[kidx];
  assign move_last  = $signed(in_tok.pos) <= $signed(cell_last[kidx]);
  assign move_first = $signed(in_tok.pos) < $signed(cell_first[kidx]);

  always_comb begin
    tok_next = in_tok;
    if (live) begin
      case (in_tok.cmd)
        CMD_APPEND: begin
          // the next cell may be the append slot and needs our shifts
          tok_next.prev_first_shift = cell_first_shift[kidx];
          tok_next.prev_last_shift  = cell_last_shift[kidx];
        end
        CMD_FIND: begin
          if (!in_tok.done && ($signed(in_tok.pos) <= $signed(shifted_last))) begin
            tok_next.done = 1'b1;
            if ($signed(shifted_first) <= $signed(in_tok.pos)) begin
              tok_next.found           = 1'b1;
              tok_next.hit_first       = cell_first[kidx];
              tok_next.hit_last        = cell_last[kidx];
              tok_next.hit_first_shift = cell_first_shift[kidx];
              tok_next.hit_last_shift  = cell_last_shift[kidx];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_tok <= tok_next;
    if (append_here) begin
      cell_first[kidx]       <= in_tok.spos + in_tok.prev_first_shift;
      cell_last[kidx]        <= in_tok.epos + in_tok.prev_last_shift;
      cell_first_shift[kidx] <= '0;
      cell_last_shift[kidx]  <= '0;
    end else if (live && (in_tok.cmd == CMD_REBASE)) begin
      if (move_last) begin
        cell_last[kidx]       <= cell_last[kidx] + in_tok.delta;
        cell_last_shift[kidx] <= cell_last_shift[kidx] + in_tok.delta;
      end
      if (move_first) begin
        cell_first[kidx]       <= cell_first[kidx] + in_tok.delta;
        cell_first_shift[kidx] <= cell_first_shift[kidx] + in_tok.delta;
      end
    end
  end

endmodule

// File: design/shifting_range_table_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake           payload
// request   in         start && !busy      command markup_kind start_pos end_pos position
//                                          delta flag_value
// result    out        done (one cycle)    status found hit_first hit_last hit_first_shift
//                                          hit_last_shift layout_valid
//
// every request gives one result, registered at the head of the chain and then in each cell:
// it walks the row of range cells, one cell per cycle, whatever the command.
// busy stays high from the request until the result strobe, so one request at a time.
// synchronous reset empties all tables and clears the layout flags.
// the receiver cannot stall; done is a single-cycle strobe.

module shifting_range_table_top import srt_pkg::*; #(
  parameter int RANGES_PER_KIND = 16,
  parameter int KIND_COUNT      = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         command,
  input  logic               markup_kind,
  input  logic signed [31:0] start_pos,
  input  logic signed [31:0] end_pos,
  input  logic signed [31:0] position,
  input  logic signed [31:0] delta,
  input  logic               flag_value,
  output logic               done,
  output logic               status,
  output logic               found,
  output logic signed [31:0] hit_first,
  output logic signed [31:0] hit_last,
  output logic signed [31:0] hit_first_shift,
  output logic signed [31:0] hit_last_shift,
  output logic               layout_valid
);

  localparam int CW = $clog2(RANGES_PER_KIND + 1);
  localparam int KW = (KIND_COUNT > 1) ? $clog2(KIND_COUNT) : 1;

  logic [CW-1:0] entry_count [KIND_COUNT];
  logic          layout_flag [KIND_COUNT];
  logic [CW-1:0] scan_count;
  logic          result_status;
  logic          result_flag;

  logic          valid_chain [RANGES_PER_KIND+1];
  token_t        tok_chain   [RANGES_PER_KIND+1];

  logic          accept;
  cmd_t          cmd;
  logic [KW-1:0] kidx;
  logic          kind_ok;
  logic [CW-1:0] cur_count;
  logic          cur_flag;
  logic          full;
  logic          flag_next;
  logic [CW-1:0] count_next;
  token_t        head_next;

  assign accept  = start && !busy;
  assign cmd     = cmd_t'(command);
  assign kidx    = KW'(markup_kind);
  assign kind_ok = (32'(markup_kind) < KIND_COUNT);
  assign cur_count = kind_ok ? entry_count[kidx] : '0;
  assign cur_flag  = kind_ok ? layout_flag[kidx] : 1'b0;
  assign full      = (cur_count == CW'(RANGES_PER_KIND));

  always_comb begin
    flag_next  = cur_flag;
    count_next = cur_count;
    case (cmd)
      CMD_APPEND: begin
        if (!full) begin
          flag_next  = 1'b0;
          count_next = cur_count + CW'(1);
        end
      end
      CMD_CLEAR: begin
        flag_next  = 1'b0;
        count_next = '0;
      end
      CMD_SET_FLAG: flag_next = flag_value;
      default: begin
      end
    endcase
  end

  always_comb begin
    head_next                  = '0;
    head_next.cmd              = cmd;
    head_next.kind             = markup_kind;
    head_next.kind_ok          = kind_ok;
    head_next.spos             = start_pos;
    head_next.epos             = end_pos;
    head_next.pos              = position;
    head_next.delta            = delta;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy           <= 1'b0;
      valid_chain[0] <= 1'b0;
      scan_count     <= '0;
      for (int k = 0; k < KIND_COUNT; k++) begin
        entry_count[k] <= '0;
        layout_flag[k] <= 1'b0;
      end
    end else begin
      valid_chain[0] <= accept;
      if (accept) begin
        busy          <= 1'b1;
        tok_chain[0]  <= head_next;
        scan_count    <= cur_count;
        result_status <= kind_ok && (cmd == CMD_APPEND) && full;
        result_flag   <= kind_ok && flag_next;
        if (kind_ok) begin
          entry_count[kidx] <= count_next;
          layout_flag[kidx] <= flag_next;
        end
      end else if (done) begin
        busy <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < RANGES_PER_KIND; i++) begin : g_cell
    srt_cell #(
      .KIND_COUNT (KIND_COUNT),
      .IDX        (i),
      .CW         (CW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .active_count (scan_count),
      .in_valid     (valid_chain[i]),
      .in_tok       (tok_chain[i]),
      .out_valid    (valid_chain[i+1]),
      .out_tok      (tok_chain[i+1])
    );
  end

  assign done            = valid_chain[RANGES_PER_KIND];
  assign status          = result_status;
  assign found           = tok_chain[RANGES_PER_KIND].found;
  assign hit_first       = tok_chain[RANGES_PER_KIND].hit_first;
  assign hit_last        = tok_chain[RANGES_PER_KIND].hit_last;
  assign hit_first_shift = tok_chain[RANGES_PER_KIND].hit_first_shift;
  assign hit_last_shift  = tok_chain[RANGES_PER_KIND].hit_last_shift;
  assign layout_valid    = result_flag;

  a_done_while_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("result strobe without a pending request");

  a_fixed_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(RANGES_PER_KIND + 1) done) else $error("result latency wrong");

  a_found_only_find: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (tok_chain[RANGES_PER_KIND].cmd == CMD_FIND))
    else $error("hit reported for a non-find request");

  // a dropped append leaves the flag as it was, so only the hit is excluded
  a_status_only_append: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> !found)
    else $error("dropped append reported with a hit");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    scan_count <= CW'(RANGES_PER_KIND)) else $error("table count overflow");

endmodule

// File: tb/sv/range_table_checker.sv
`timescale 1ns / 1ps

module range_table_checker import srt_pkg::*; #(
  parameter int RANGES_PER_KIND = 16,
  parameter int KIND_COUNT      = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  command,
  input  logic        markup_kind,
  input  logic [31:0] start_pos,
  input  logic [31:0] end_pos,
  input  logic [31:0] position,
  input  logic [31:0] delta,
  input  logic        flag_value,
  input  logic        done,
  input  logic        status,
  input  logic        found,
  input  logic [31:0] hit_first,
  input  logic [31:0] hit_last,
  input  logic [31:0] hit_first_shift,
  input  logic [31:0] hit_last_shift,
  input  logic        layout_valid,
  output int          pending,
  output int          mismatches,
  output int          hits,
  output int          drops
);

  typedef struct packed {
    logic        status;
    logic        found;
    logic [31:0] first;
    logic [31:0] last;
    logic [31:0] first_shift;
    logic [31:0] last_shift;
    logic        flag;
  } table_reply_t;

  logic [31:0]  range_first       [KIND_COUNT][RANGES_PER_KIND];
  logic [31:0]  range_last        [KIND_COUNT][RANGES_PER_KIND];
  logic [31:0]  range_first_shift [KIND_COUNT][RANGES_PER_KIND];
  logic [31:0]  range_last_shift  [KIND_COUNT][RANGES_PER_KIND];
  int unsigned  ranges_used       [KIND_COUNT];
  logic         layout_ok         [KIND_COUNT];
  table_reply_t pending_replies[$];
  int           error_count = 0;
  int           hit_count   = 0;
  int           drop_count  = 0;

  initial begin
    pending    = 0;
    mismatches = 0;
    hits       = 0;
    drops      = 0;
  end

  // updates the table copy for one request and returns the reply it should give
  function automatic table_reply_t predict_table_step(
    logic [2:0] cmd, logic kind, logic [31:0] spos, logic [31:0] epos,
    logic [31:0] pos, logic [31:0] dlt, logic fv);
    table_reply_t r;
    int unsigned  n;
    logic [31:0]  shifted_first;
    logic [31:0]  shifted_last;
    logic         move_first;
    logic         move_last;
    r = '0;
    if (kind < KIND_COUNT) begin
      n = ranges_used[kind];
      case (cmd)
        CMD_APPEND: begin
          if (n >= RANGES_PER_KIND) begin
            r.status = 1'b1;
          end else begin
            range_first[kind][n] = spos;
            range_last[kind][n]  = epos;
            // new range inherits the shifts of the entry before it
            if (n > 0) begin
              range_first[kind][n] = spos + range_first_shift[kind][n-1];
              range_last[kind][n]  = epos + range_last_shift[kind][n-1];
            end
            range_first_shift[kind][n] = '0;
            range_last_shift[kind][n]  = '0;
            ranges_used[kind] = n + 1;
            layout_ok[kind] = 1'b0;
          end
        end
        CMD_CLEAR: begin
          ranges_used[kind] = 0;
          layout_ok[kind] = 1'b0;
        end
        CMD_FIND: begin
          for (int i = 0; i < n; i++) begin
            shifted_last = range_last[kind][i] + range_last_shift[kind][i];
            if ($signed(pos) <= $signed(shifted_last)) begin
              shifted_first = range_first[kind][i] + range_first_shift[kind][i];
              if ($signed(shifted_first) <= $signed(pos)) begin
                r.found       = 1'b1;
                r.first       = range_first[kind][i];
                r.last        = range_last[kind][i];
                r.first_shift = range_first_shift[kind][i];
                r.last_shift  = range_last_shift[kind][i];
              end
              break;
            end
          end
        end
        CMD_REBASE: begin
          for (int i = 0; i < n; i++) begin
            // both tests look at the stored ends before this rebase
            move_last  = $signed(pos) <= $signed(range_last[kind][i]);
            move_first = $signed(pos) < $signed(range_first[kind][i]);
            if (move_last) begin
              range_last[kind][i]       = range_last[kind][i] + dlt;
              range_last_shift[kind][i] = range_last_shift[kind][i] + dlt;
            end
            if (move_first) begin
              range_first[kind][i]       = range_first[kind][i] + dlt;
              range_first_shift[kind][i] = range_first_shift[kind][i] + dlt;
            end
          end
        end
        CMD_SET_FLAG: layout_ok[kind] = fv;
        default: ;
      endcase
      r.flag = layout_ok[kind];
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= 10)
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    table_reply_t want;
    if (rst) begin
      for (int k = 0; k < KIND_COUNT; k++) begin
        ranges_used[k] = 0;
        layout_ok[k] = 1'b0;
      end
      pending_replies.delete();
    end else begin
      if (done) begin
        if (pending_replies.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: result strobe with no request outstanding", $time);
        end else begin
          want = pending_replies.pop_front();
          check_field("status", want.status, status);
          check_field("found", want.found, found);
          check_field("hit_first", want.first, hit_first);
          check_field("hit_last", want.last, hit_last);
          check_field("hit_first_shift", want.first_shift, hit_first_shift);
          check_field("hit_last_shift", want.last_shift, hit_last_shift);
          check_field("layout_valid", want.flag, layout_valid);
          if (want.found) hit_count++;
          if (want.status) drop_count++;
        end
      end
      if (start && !busy)
        pending_replies.push_back(predict_table_step(command, markup_kind, start_pos,
                                                     end_pos, position, delta, flag_value));
    end
    pending    <= pending_replies.size();
    mismatches <= error_count;
    hits       <= hit_count;
    drops      <= drop_count;
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench import srt_pkg::*;;

  localparam int RANGES_PER_KIND = 16;
  localparam int KIND_COUNT      = 2;
  localparam int RANDOM_REQUESTS = 950;

  logic        clk = 1'b0;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  command;
  logic        markup_kind;
  logic [31:0] start_pos;
  logic [31:0] end_pos;
  logic [31:0] position;
  logic [31:0] delta;
  logic        flag_value;
  logic        done;
  logic        status;
  logic        found;
  logic [31:0] hit_first;
  logic [31:0] hit_last;
  logic [31:0] hit_first_shift;
  logic [31:0] hit_last_shift;
  logic        layout_valid;
  int          pending;
  int          mismatches;
  int          hits;
  int          drops;
  int          command_tally [8];

  always #10 clk = ~clk;

  shifting_range_table_top #(
    .RANGES_PER_KIND (RANGES_PER_KIND),
    .KIND_COUNT      (KIND_COUNT)
  ) u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .markup_kind     (markup_kind),
    .start_pos       (start_pos),
    .end_pos         (end_pos),
    .position        (position),
    .delta           (delta),
    .flag_value      (flag_value),
    .done            (done),
    .status          (status),
    .found           (found),
    .hit_first       (hit_first),
    .hit_last        (hit_last),
    .hit_first_shift (hit_first_shift),
    .hit_last_shift  (hit_last_shift),
    .layout_valid    (layout_valid)
  );

  range_table_checker #(
    .RANGES_PER_KIND (RANGES_PER_KIND),
    .KIND_COUNT      (KIND_COUNT)
  ) u_check (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .command         (command),
    .markup_kind     (markup_kind),
    .start_pos       (start_pos),
    .end_pos         (end_pos),
    .position        (position),
    .delta           (delta),
    .flag_value      (flag_value),
    .done            (done),
    .status          (status),
    .found           (found),
    .hit_first       (hit_first),
    .hit_last        (hit_last),
    .hit_first_shift (hit_first_shift),
    .hit_last_shift  (hit_last_shift),
    .layout_valid    (layout_valid),
    .pending         (pending),
    .mismatches      (mismatches),
    .hits            (hits),
    .drops           (drops)
  );

  // holds the request until the block takes it, then maybe leaves a gap
  task automatic send_request(logic [2:0] cmd, logic kind, logic [31:0] spos,
                              logic [31:0] epos, logic [31:0] pos, logic [31:0] dlt,
                              logic fv, bit may_idle);
    start       <= 1'b1;
    command     <= cmd;
    markup_kind <= kind;
    start_pos   <= spos;
    end_pos     <= epos;
    position    <= pos;
    delta       <= dlt;
    flag_value  <= fv;
    do @(posedge clk); while (busy);
    command_tally[cmd]++;
    if (may_idle && $urandom_range(0, 99) < 28) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  task automatic drain_table;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int          pick;
    logic        kind;
    logic [2:0]  op;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] p;
    logic [31:0] d;
    logic [31:0] cursor [KIND_COUNT];

    rst         = 1'b1;
    start       = 1'b0;
    command     = CMD_FIND;
    markup_kind = 1'b0;
    start_pos   = '0;
    end_pos     = '0;
    position    = '0;
    delta       = '0;
    flag_value  = 1'b0;
    foreach (command_tally[i]) command_tally[i] = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, wraparound, empty and full tables, undefined commands
    send_request(CMD_SET_FLAG, 1'b0, $urandom, $urandom, $urandom, $urandom, 1'b1, 1'b1);
    send_request(CMD_FIND, 1'b0, $urandom, $urandom, 32'd0, $urandom, 1'b0, 1'b1);
    send_request(CMD_APPEND, 1'b0, 32'h8000_0000, 32'h7fff_ffff, $urandom, $urandom,
                 1'b0, 1'b1);
    send_request(CMD_FIND, 1'b0, $urandom, $urandom, 32'd0, $urandom, 1'b1, 1'b1);
    send_request(CMD_REBASE, 1'b0, $urandom, $urandom, 32'h8000_0000, 32'h7fff_ffff,
                 1'b0, 1'b1);
    send_request(CMD_FIND, 1'b0, $urandom, $urandom, 32'h7fff_ffff, $urandom, 1'b0, 1'b1);
    send_request(CMD_APPEND, 1'b0, 32'd5, 32'd9, $urandom, $urandom, 1'b0, 1'b1);
    send_request(CMD_REBASE, 1'b0, $urandom, $urandom, 32'd0, 32'h8000_0000, 1'b1, 1'b1);
    send_request(3'd5, 1'b0, $urandom, $urandom, $urandom, $urandom, 1'b1, 1'b1);
    send_request(3'd7, 1'b1, $urandom, $urandom, $urandom, $urandom, 1'b0, 1'b1);
    // one append past the end of the grammar table
    for (int i = 0; i <= RANGES_PER_KIND; i++)
      send_request(CMD_APPEND, 1'b1, i * 10, i * 10 + 4, $urandom, $urandom, 1'b0, 1'b1);
    send_request(CMD_CLEAR, 1'b1, $urandom, $urandom, $urandom, $urandom, 1'b1, 1'b1);
    drain_table();

    foreach (cursor[k]) cursor[k] = $urandom_range(0, 1000);
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      kind = 1'($urandom_range(0, 1));
      a = $urandom;
      b = $urandom;
      p = $urandom;
      d = $urandom;
      op = CMD_FIND;
      if (pick < 10) begin
        op = 3'($urandom_range(0, 7));
      end else if (pick < 40) begin
        // ascending, mostly non-overlapping ranges
        op = CMD_APPEND;
        a = cursor[kind] + $urandom_range(0, 6);
        b = a + $urandom_range(0, 12);
        cursor[kind] = b + 1;
      end else if (pick < 70) begin
        op = CMD_FIND;
        p = cursor[kind] - $urandom_range(0, 120) + 10;
      end else if (pick < 85) begin
        op = CMD_REBASE;
        p = cursor[kind] - $urandom_range(0, 120);
        d = $urandom_range(0, 60) - 32'd30;
      end else if (pick < 91) begin
        op = CMD_SET_FLAG;
      end else if (pick < 95) begin
        op = CMD_CLEAR;
        // some tables restart just below the wrap point
        if ($urandom_range(0, 3) == 0) cursor[kind] = 32'h7fff_ff00 + $urandom_range(0, 200);
        else cursor[kind] = $urandom_range(0, 1000);
      end else begin
        op = 3'($urandom_range(5, 7));
      end
      send_request(op, kind, a, b, p, d, 1'($urandom_range(0, 1)), n < 300 || n >= 550);
      if (n == 650) drain_table();
    end

    drain_table();
    repeat (RANGES_PER_KIND + 4) @(posedge clk);
    $display("covered %0d requests: %0d appends (%0d dropped on a full table),",
             command_tally.sum(), command_tally[CMD_APPEND], drops);
    $display("  %0d finds (%0d hits), %0d rebases, %0d clears, %0d flag writes, %0d undefined",
             command_tally[CMD_FIND], hits, command_tally[CMD_REBASE],
             command_tally[CMD_CLEAR], command_tally[CMD_SET_FLAG],
             command_tally[5] + command_tally[6] + command_tally[7]);
    if (mismatches == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
